// ===== rtl/core/mccd_pkg.sv =====
// ----------------------------------------------------------------------------
// mccd_pkg
// shared types and constants of the meter clock calibrated drive core
// ----------------------------------------------------------------------------
package mccd_pkg;

   localparam int MAX_POINTS_DEFAULT = 8;
   localparam int DRIVE_BITS_DEFAULT = 10;

   localparam int POS_BITS       = 17;
   localparam int HOURS_BITS     = 5;
   localparam int MINUTES_BITS   = 6;
   localparam int SECONDS_BITS   = 6;
   localparam int CHANNEL_BITS   = 2;
   localparam int CAL_INDEX_BITS = 3;
   localparam int PCNT_BITS      = 4;
   localparam int NUM_CHANNELS   = 3;

   localparam int HOURS_MAX    = 24;
   localparam int MINSEC_MAX   = 60;
   localparam int SEC_PER_HOUR = 3600;
   localparam int SEC_PER_MIN  = 60;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DISCRETE_MODE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOUR_POINTS   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MINUTE_POINTS = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SECOND_POINTS = 4'd3;

   localparam logic [CHANNEL_BITS-1:0] CH_HOUR   = 2'd0;
   localparam logic [CHANNEL_BITS-1:0] CH_MINUTE = 2'd1;
   localparam logic [CHANNEL_BITS-1:0] CH_SECOND = 2'd2;

   localparam logic OP_SET_TIME   = 1'b0;
   localparam logic OP_LOAD_POINT = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FIRST,
      ST_SCAN,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_STORE,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/core/mccd_ram.sv =====
// ----------------------------------------------------------------------------
// mccd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mccd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mccd_divider.sv =====
// ----------------------------------------------------------------------------
// mccd_divider
// unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module mccd_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int STEPS = (NUM_W + 1) / 2;
   localparam int PAD_W = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [PAD_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_step;
   logic [PAD_W-1:0] quo_step;

   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int k = 0; k < 2; k++) begin
         rem_step = {rem_step[DEN_W-1:0], quo_step[PAD_W-1]};
         quo_step = {quo_step[PAD_W-2:0], 1'b0};
         if (rem_step >= {1'b0, den_ff}) begin
            rem_step    = rem_step - {1'b0, den_ff};
            quo_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = PAD_W'(numer);
         den_in = denom;
         cnt_in = CNT_W'(STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff[NUM_W-1:0];

endmodule

// ===== rtl/core/meter_clock_calibrated_drive_core.sv =====
// ----------------------------------------------------------------------------
// meter_clock_calibrated_drive_core
// time of day to calibrated drive values for hour, minute and second meters
// ----------------------------------------------------------------------------
// A calibration point load or an out-of-range time gives its response strobe in
// the cycle after the transfer. A valid time walks the hour, minute and second
// tables one after another through the single read port of the calibration
// ram, one point per cycle, and, when the time lies between two points, runs
// one interpolation division on a shared divider that yields two quotient
// bits per cycle. busy stays high until the response strobe has been shown,
// and rsp_valid lasts one cycle and is not held for the receiver.
// ----------------------------------------------------------------------------
module meter_clock_calibrated_drive_core
   import mccd_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
   parameter int DRIVE_BITS = DRIVE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic [HOURS_BITS-1:0]     req_hours,
   input  logic [MINUTES_BITS-1:0]   req_minutes,
   input  logic [SECONDS_BITS-1:0]   req_seconds,
   input  logic [CHANNEL_BITS-1:0]   req_cal_channel,
   input  logic [CAL_INDEX_BITS-1:0] req_cal_index,
   input  logic [POS_BITS-1:0]       req_cal_position,
   input  logic [DRIVE_BITS-1:0]     req_cal_drive,
   output logic                      rsp_valid,
   output logic                      rsp_status,
   output logic [DRIVE_BITS-1:0]     rsp_hour_drive,
   output logic [DRIVE_BITS-1:0]     rsp_minute_drive,
   output logic [DRIVE_BITS-1:0]     rsp_second_drive,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DEPTH   = NUM_CHANNELS * MAX_POINTS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = IDX_W + 1;
   localparam int CMP_W   = (CNT_W > PCNT_BITS) ? CNT_W : PCNT_BITS;
   localparam int WIDE_W  = (CMP_W > CAL_INDEX_BITS) ? CMP_W : CAL_INDEX_BITS;
   localparam int ENTRY_W = POS_BITS + DRIVE_BITS;
   localparam int MAG_W   = POS_BITS + DRIVE_BITS;
   localparam int WADDR_W = ADDR_W + CHANNEL_BITS + CAL_INDEX_BITS;

   state_type state_ff, state_in;

   logic                   discrete_ff, discrete_in;
   logic [PCNT_BITS-1:0]   pts_ff [NUM_CHANNELS];
   logic [PCNT_BITS-1:0]   pts_in [NUM_CHANNELS];
   logic [DRIVE_BITS-1:0]  last_ff [NUM_CHANNELS];
   logic [DRIVE_BITS-1:0]  last_in [NUM_CHANNELS];
   logic [POS_BITS-1:0]    xpos_ff [NUM_CHANNELS];
   logic [POS_BITS-1:0]    xpos_in [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] ch_ff, ch_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   status_ff, status_in;
   logic [POS_BITS-1:0]    prev_pos_ff, prev_pos_in;
   logic [DRIVE_BITS-1:0]  prev_drv_ff, prev_drv_in;
   logic [POS_BITS-1:0]    span_ff, span_in;
   logic [POS_BITS-1:0]    dx_ff, dx_in;
   logic [DRIVE_BITS-1:0]  dd_mag_ff, dd_mag_in;
   logic                   neg_ff, neg_in;
   logic [MAG_W-1:0]       prod_ff, prod_in;
   logic [DRIVE_BITS-1:0]  res_ff, res_in;

   logic                   accept;
   logic                   range_err;
   logic [POS_BITS-1:0]    h_sec, m_sec, s_sec;
   logic [POS_BITS-1:0]    x_cur;
   logic [CNT_W-1:0]       n_eff;
   logic [CNT_W-1:0]       idx_next;
   logic                   more;
   logic [ADDR_W-1:0]      base;
   logic [CNT_W-1:0]       rd_off;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   logic [POS_BITS-1:0]    rd_pos;
   logic [DRIVE_BITS-1:0]  rd_drv;
   logic                   wr_en;
   logic [WADDR_W-1:0]     wr_addr_wide;
   logic                   div_start;
   logic                   div_done;
   logic [MAG_W-1:0]       div_quot;
   logic [DRIVE_BITS-1:0]  quot_lo;

   // request decode
   assign accept    = start && !busy;
   assign range_err = (req_hours > HOURS_BITS'(HOURS_MAX))
                   || (req_minutes > MINUTES_BITS'(MINSEC_MAX))
                   || (req_seconds > SECONDS_BITS'(MINSEC_MAX));
   assign h_sec = POS_BITS'(req_hours) * POS_BITS'(SEC_PER_HOUR);
   assign m_sec = POS_BITS'(req_minutes) * POS_BITS'(SEC_PER_MIN);
   assign s_sec = POS_BITS'(req_seconds);

   // current table
   assign x_cur    = xpos_ff[ch_ff];
   assign n_eff    = (CMP_W'(pts_ff[ch_ff]) > CMP_W'(MAX_POINTS))
                   ? CNT_W'(MAX_POINTS) : CNT_W'(pts_ff[ch_ff]);
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign more     = idx_next < n_eff;
   assign base     = ADDR_W'(ch_ff) * ADDR_W'(MAX_POINTS);
   assign rd_pos   = rd_data[ENTRY_W-1 -: POS_BITS];
   assign rd_drv   = rd_data[DRIVE_BITS-1:0];
   assign quot_lo  = div_quot[DRIVE_BITS-1:0];

   assign wr_addr_wide = WADDR_W'(req_cal_channel) * WADDR_W'(MAX_POINTS)
                       + WADDR_W'(req_cal_index);

   mccd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_cal_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_wide[ADDR_W-1:0]),
      .wr_data ({req_cal_position, req_cal_drive}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mccd_divider #(
      .NUM_W (MAG_W),
      .DEN_W (POS_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_ff),
      .denom (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD_POINT || range_err) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: state_in = ST_FIRST;
         ST_FIRST: begin
            if (n_eff < CNT_W'(2) || x_cur <= rd_pos) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (x_cur <= rd_pos) begin
               state_in = ST_MUL;
            end else if (!more) begin
               state_in = ST_STORE;
            end
         end
         ST_MUL:    state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (ch_ff == CH_SECOND) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_off    = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_FIRST:  rd_off = CNT_W'(1);
         ST_SCAN:   rd_off = more ? idx_next : '0;
         ST_DIV_GO: div_start = 1'b1;
         default: begin
            rd_off    = '0;
            div_start = 1'b0;
         end
      endcase
   end

   assign rd_addr   = base + ADDR_W'(rd_off);
   assign wr_en     = accept && (req_operation == OP_LOAD_POINT)
                   && (req_cal_channel <= CH_SECOND)
                   && (WIDE_W'(req_cal_index) < WIDE_W'(MAX_POINTS));
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_status       = status_ff;
   assign rsp_hour_drive   = last_ff[CH_HOUR];
   assign rsp_minute_drive = last_ff[CH_MINUTE];
   assign rsp_second_drive = last_ff[CH_SECOND];
   assign csr_ready = 1'b1;

   // config registers
   always_comb begin
      discrete_in = discrete_ff;
      pts_in      = pts_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DISCRETE_MODE: discrete_in       = csr_wdata[0];
            REG_HOUR_POINTS:   pts_in[CH_HOUR]   = csr_wdata;
            REG_MINUTE_POINTS: pts_in[CH_MINUTE] = csr_wdata;
            REG_SECOND_POINTS: pts_in[CH_SECOND] = csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      xpos_in     = xpos_ff;
      last_in     = last_ff;
      ch_in       = ch_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      prev_pos_in = prev_pos_ff;
      prev_drv_in = prev_drv_ff;
      span_in     = span_ff;
      dx_in       = dx_ff;
      dd_mag_in   = dd_mag_ff;
      neg_in      = neg_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in     = CH_HOUR;
               status_in = (req_operation == OP_SET_TIME && range_err)
                         ? STATUS_RANGE : STATUS_OK;
               if (discrete_ff) begin
                  xpos_in[CH_HOUR]   = h_sec;
                  xpos_in[CH_MINUTE] = m_sec;
               end else begin
                  xpos_in[CH_HOUR]   = h_sec + m_sec + s_sec;
                  xpos_in[CH_MINUTE] = m_sec + s_sec;
               end
               xpos_in[CH_SECOND] = s_sec;
            end
         end
         ST_FIRST: begin
            if (n_eff < CNT_W'(2) || x_cur < rd_pos) begin
               res_in = '0;
            end else if (x_cur == rd_pos) begin
               res_in = rd_drv;
            end else begin
               prev_pos_in = rd_pos;
               prev_drv_in = rd_drv;
               idx_in      = IDX_W'(1);
            end
         end
         ST_SCAN: begin
            if (x_cur <= rd_pos) begin
               dx_in     = x_cur - prev_pos_ff;
               span_in   = rd_pos - prev_pos_ff;
               neg_in    = rd_drv < prev_drv_ff;
               dd_mag_in = (rd_drv < prev_drv_ff) ? prev_drv_ff - rd_drv
                                                  : rd_drv - prev_drv_ff;
            end else if (more) begin
               prev_pos_in = rd_pos;
               prev_drv_in = rd_drv;
               idx_in      = idx_next[IDX_W-1:0];
            end else begin
               res_in = rd_drv;
            end
         end
         ST_MUL: prod_in = MAG_W'(dx_ff) * MAG_W'(dd_mag_ff);
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_in = neg_ff ? prev_drv_ff - quot_lo : prev_drv_ff + quot_lo;
            end
         end
         ST_STORE: begin
            last_in[ch_ff] = res_ff;
            if (ch_ff != CH_SECOND) begin
               ch_in = ch_ff + CHANNEL_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         discrete_ff <= 1'b0;
         ch_ff       <= CH_HOUR;
         idx_ff      <= '0;
         status_ff   <= STATUS_OK;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            pts_ff[c]  <= '0;
            last_ff[c] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         discrete_ff <= discrete_in;
         ch_ff       <= ch_in;
         idx_ff      <= idx_in;
         status_ff   <= status_in;
         pts_ff      <= pts_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      xpos_ff     <= xpos_in;
      prev_pos_ff <= prev_pos_in;
      prev_drv_ff <= prev_drv_in;
      span_ff     <= span_in;
      dx_ff       <= dx_in;
      dd_mag_ff   <= dd_mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
   end

endmodule

// ===== rtl/core/mccd_checker.sv =====
// ----------------------------------------------------------------------------
// mccd_checker
// port level checks of the meter clock calibrated drive core
// ----------------------------------------------------------------------------
module mccd_checker
   import mccd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    req_operation,
   input logic [HOURS_BITS-1:0]   req_hours,
   input logic [MINUTES_BITS-1:0] req_minutes,
   input logic [SECONDS_BITS-1:0] req_seconds,
   input logic                    rsp_valid,
   input logic                    rsp_status
);

   logic accept;
   logic bad_time;

   assign accept   = start && !busy;
   assign bad_time = (req_hours > HOURS_BITS'(HOURS_MAX))
                  || (req_minutes > MINUTES_BITS'(MINSEC_MAX))
                  || (req_seconds > SECONDS_BITS'(MINSEC_MAX));

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe without busy");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy after response");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after transfer");

   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_LOAD_POINT)
      |=> (rsp_valid && rsp_status == STATUS_OK))
      else $error("load point response missing or wrong");

   a_range_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_SET_TIME && bad_time)
      |=> (rsp_valid && rsp_status == STATUS_RANGE))
      else $error("range error response missing or wrong");

endmodule

bind meter_clock_calibrated_drive_core mccd_checker u_mccd_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for meter_clock_calibrated_drive_core: time and
// calibration point commands go in through start/busy, each response strobe is
// checked against an in-bench interpolation predictor, and the point count and
// discrete mode registers are changed between phases while the core is idle
// ----------------------------------------------------------------------------
module tb
   import mccd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PTS = MAX_POINTS_DEFAULT;
   localparam int DRV_W = DRIVE_BITS_DEFAULT;
   localparam int POS_MAX = 2 ** POS_BITS - 1;
   localparam int DRV_MAX = 2 ** DRV_W - 1;
   localparam int HOUR_SPAN = HOURS_MAX * SEC_PER_HOUR + MINSEC_MAX * SEC_PER_MIN
                            + MINSEC_MAX;
   localparam int MINUTE_SPAN = MINSEC_MAX * SEC_PER_MIN + MINSEC_MAX;
   localparam int SETTLE_CYCLES = 90;
   localparam int PHASE_ITEMS = 80;
   localparam int RANDOM_PHASES = 12;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 4'd9;
   localparam logic [CHANNEL_BITS-1:0] CH_NONE = 2'd3;

   typedef struct {
      logic                      op;
      logic [HOURS_BITS-1:0]     hours;
      logic [MINUTES_BITS-1:0]   minutes;
      logic [SECONDS_BITS-1:0]   seconds;
      logic [CHANNEL_BITS-1:0]   ch;
      logic [CAL_INDEX_BITS-1:0] idx;
      logic [POS_BITS-1:0]       pos;
      logic [DRV_W-1:0]          drv;
      bit                        drain;
   } meter_cmd_type;

   typedef struct {
      logic             status;
      logic [DRV_W-1:0] hour;
      logic [DRV_W-1:0] minute;
      logic [DRV_W-1:0] second;
   } meter_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_operation = 1'b0;
   logic [HOURS_BITS-1:0]     req_hours = '0;
   logic [MINUTES_BITS-1:0]   req_minutes = '0;
   logic [SECONDS_BITS-1:0]   req_seconds = '0;
   logic [CHANNEL_BITS-1:0]   req_cal_channel = '0;
   logic [CAL_INDEX_BITS-1:0] req_cal_index = '0;
   logic [POS_BITS-1:0]       req_cal_position = '0;
   logic [DRV_W-1:0]          req_cal_drive = '0;
   logic                      rsp_valid;
   logic                      rsp_status;
   logic [DRV_W-1:0]          rsp_hour_drive;
   logic [DRV_W-1:0]          rsp_minute_drive;
   logic [DRV_W-1:0]          rsp_second_drive;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   meter_clock_calibrated_drive_core #(
      .MAX_POINTS(MAX_PTS),
      .DRIVE_BITS(DRV_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_hours(req_hours),
      .req_minutes(req_minutes),
      .req_seconds(req_seconds),
      .req_cal_channel(req_cal_channel),
      .req_cal_index(req_cal_index),
      .req_cal_position(req_cal_position),
      .req_cal_drive(req_cal_drive),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_hour_drive(rsp_hour_drive),
      .rsp_minute_drive(rsp_minute_drive),
      .rsp_second_drive(rsp_second_drive),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   bit                   discrete;
   logic [PCNT_BITS-1:0] point_cnt [NUM_CHANNELS];
   int unsigned          cal_pos [NUM_CHANNELS * MAX_PTS];
   int unsigned          cal_drv [NUM_CHANNELS * MAX_PTS];
   logic [DRV_W-1:0]     last_drv [NUM_CHANNELS];

   meter_cmd_type pending_cmds[$];
   meter_rsp_type expected_drives[$];
   meter_cmd_type cur_cmd;
   meter_rsp_type want;
   bit            sending;
   bit            steady;
   int            mismatch_count;

   function automatic logic [DRV_W-1:0] drive_at(input logic [CHANNEL_BITS-1:0] ch,
                                                 input int unsigned x);
      int     n;
      int     i;
      int     base;
      longint dx;
      longint span;
      longint dd;
      longint q;
      n = (point_cnt[ch] > MAX_PTS) ? MAX_PTS : int'(point_cnt[ch]);
      base = int'(ch) * MAX_PTS;
      if (n < 2 || x < cal_pos[base]) return '0;
      if (x == cal_pos[base]) return DRV_W'(cal_drv[base]);
      i = 1;
      while (i < n && x > cal_pos[base + i]) i++;
      if (i >= n) return DRV_W'(cal_drv[base + n - 1]);
      dx = longint'(x) - longint'(cal_pos[base + i - 1]);
      span = longint'(cal_pos[base + i]) - longint'(cal_pos[base + i - 1]);
      dd = longint'(cal_drv[base + i]) - longint'(cal_drv[base + i - 1]);
      q = (dx * dd) / span;
      return DRV_W'(q + longint'(cal_drv[base + i - 1]));
   endfunction

   function automatic meter_rsp_type step_meters(input meter_cmd_type c);
      meter_rsp_type r;
      int unsigned   hpos;
      int unsigned   mpos;
      r.status = STATUS_OK;
      if (c.op == OP_LOAD_POINT) begin
         if (c.ch < NUM_CHANNELS && c.idx < MAX_PTS) begin
            cal_pos[int'(c.ch) * MAX_PTS + int'(c.idx)] = 32'(c.pos);
            cal_drv[int'(c.ch) * MAX_PTS + int'(c.idx)] = 32'(c.drv);
         end
      end else if (c.hours > HOURS_MAX || c.minutes > MINSEC_MAX
                   || c.seconds > MINSEC_MAX) begin
         r.status = STATUS_RANGE;
      end else begin
         if (discrete) begin
            hpos = c.hours * SEC_PER_HOUR;
            mpos = c.minutes * SEC_PER_MIN;
         end else begin
            hpos = c.hours * SEC_PER_HOUR + c.minutes * SEC_PER_MIN + c.seconds;
            mpos = c.minutes * SEC_PER_MIN + c.seconds;
         end
         last_drv[CH_HOUR] = drive_at(CH_HOUR, hpos);
         last_drv[CH_MINUTE] = drive_at(CH_MINUTE, mpos);
         last_drv[CH_SECOND] = drive_at(CH_SECOND, 32'(c.seconds));
      end
      r.hour = last_drv[CH_HOUR];
      r.minute = last_drv[CH_MINUTE];
      r.second = last_drv[CH_SECOND];
      return r;
   endfunction

   task automatic flag_error(input string what);
      mismatch_count++;
      $display("tb: mismatch at %0t: %s", $realtime, what);
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         sending = start;
         if (start && !busy) begin
            expected_drives.push_back(step_meters(cur_cmd));
            sending = 1'b0;
         end
         if (!sending && pending_cmds.size() != 0
             && !(pending_cmds[0].drain && expected_drives.size() != 0)
             && (steady || $urandom_range(0, 99) >= 18)) begin
            cur_cmd = pending_cmds.pop_front();
            sending = 1'b1;
            req_operation <= cur_cmd.op;
            req_hours <= cur_cmd.hours;
            req_minutes <= cur_cmd.minutes;
            req_seconds <= cur_cmd.seconds;
            req_cal_channel <= cur_cmd.ch;
            req_cal_index <= cur_cmd.idx;
            req_cal_position <= cur_cmd.pos;
            req_cal_drive <= cur_cmd.drv;
         end
         start <= sending;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_drives.size() == 0) begin
            flag_error("response strobe with no transfer outstanding");
         end else begin
            want = expected_drives.pop_front();
            if (rsp_status !== want.status)
               flag_error($sformatf("status %b, expected %b", rsp_status, want.status));
            if (rsp_hour_drive !== want.hour)
               flag_error($sformatf("hour drive %0d, expected %0d", rsp_hour_drive, want.hour));
            if (rsp_minute_drive !== want.minute)
               flag_error($sformatf("minute drive %0d, expected %0d",
                                    rsp_minute_drive, want.minute));
            if (rsp_second_drive !== want.second)
               flag_error($sformatf("second drive %0d, expected %0d",
                                    rsp_second_drive, want.second));
         end
      end
   end

   task automatic push_time(input int h, input int m, input int s, input bit drain);
      meter_cmd_type c;
      c.op = OP_SET_TIME;
      c.hours = HOURS_BITS'(h);
      c.minutes = MINUTES_BITS'(m);
      c.seconds = SECONDS_BITS'(s);
      c.ch = CHANNEL_BITS'($urandom_range(0, 3));
      c.idx = CAL_INDEX_BITS'($urandom_range(0, 7));
      c.pos = POS_BITS'($urandom_range(0, POS_MAX));
      c.drv = DRV_W'($urandom_range(0, DRV_MAX));
      c.drain = drain;
      pending_cmds.push_back(c);
   endtask

   task automatic push_load(input logic [CHANNEL_BITS-1:0] ch, input int idx, input int pos,
                            input int drv, input bit drain);
      meter_cmd_type c;
      c.op = OP_LOAD_POINT;
      c.hours = HOURS_BITS'($urandom_range(0, 31));
      c.minutes = MINUTES_BITS'($urandom_range(0, 63));
      c.seconds = SECONDS_BITS'($urandom_range(0, 63));
      c.ch = ch;
      c.idx = CAL_INDEX_BITS'(idx);
      c.pos = POS_BITS'(pos);
      c.drv = DRV_W'(drv);
      c.drain = drain;
      pending_cmds.push_back(c);
   endtask

   task automatic push_random_table(input logic [CHANNEL_BITS-1:0] ch);
      int unsigned span;
      int unsigned p;
      int          k;
      span = (ch == CH_HOUR) ? HOUR_SPAN : (ch == CH_MINUTE) ? MINUTE_SPAN : MINSEC_MAX;
      p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span / 6);
      for (k = 0; k < MAX_PTS; k++) begin
         push_load(ch, k, int'(p), int'($urandom_range(0, DRV_MAX)), 1'b0);
         p = p + $urandom_range(0, span / 5);
         if (p > POS_MAX) p = POS_MAX;
      end
   endtask

   task automatic push_random_cmd();
      int r;
      int h;
      int m;
      int s;
      r = $urandom_range(0, 99);
      h = $urandom_range(0, HOURS_MAX);
      m = $urandom_range(0, MINSEC_MAX);
      s = $urandom_range(0, MINSEC_MAX);
      if (r < 12) begin
         case ($urandom_range(0, 2))
            0: h = $urandom_range(HOURS_MAX + 1, 31);
            1: m = $urandom_range(MINSEC_MAX + 1, 63);
            default: s = $urandom_range(MINSEC_MAX + 1, 63);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            h = $urandom_range(0, 31);
            m = $urandom_range(MINSEC_MAX + 1, 63);
         end
         push_time(h, m, s, $urandom_range(0, 99) < 3);
      end else if (r < 27) begin
         push_load(CHANNEL_BITS'($urandom_range(0, 3)), int'($urandom_range(0, 7)),
                   int'($urandom_range(0, POS_MAX)), int'($urandom_range(0, DRV_MAX)),
                   $urandom_range(0, 99) < 3);
      end else begin
         if (r < 30) begin
            h = HOURS_MAX;
            m = MINSEC_MAX;
            s = MINSEC_MAX;
         end else if (r < 32) begin
            h = 0;
            m = 0;
            s = 0;
         end
         push_time(h, m, s, $urandom_range(0, 99) < 3);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || expected_drives.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; caller lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(val);
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         REG_DISCRETE_MODE: discrete = val[0];
         REG_HOUR_POINTS:   point_cnt[CH_HOUR] = PCNT_BITS'(val);
         REG_MINUTE_POINTS: point_cnt[CH_MINUTE] = PCNT_BITS'(val);
         REG_SECOND_POINTS: point_cnt[CH_SECOND] = PCNT_BITS'(val);
         default: ;
      endcase
   endtask

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 1;
      if (r == 2) return $urandom_range(MAX_PTS + 1, 15);
      if (r < 6) return MAX_PTS;
      return $urandom_range(2, MAX_PTS);
   endfunction

   initial begin
      int k;
      int ph;
      int n;
      discrete = 1'b0;
      for (k = 0; k < NUM_CHANNELS; k++) begin
         point_cnt[k] = '0;
         last_drv[k] = '0;
      end
      steady = 1'b0;
      mismatch_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset state: empty tables read as zero, range errors
      push_time(0, 0, 0, 1'b0);
      push_time(HOURS_MAX, MINSEC_MAX, MINSEC_MAX, 1'b0);
      push_time(HOURS_MAX + 1, 0, 0, 1'b0);
      push_time(0, MINSEC_MAX + 1, 0, 1'b0);
      push_time(0, 0, MINSEC_MAX + 1, 1'b1);
      push_time(31, 63, 63, 1'b0);
      push_load(CH_NONE, 7, POS_MAX, DRV_MAX, 1'b0);

      // hour rising, minute falling, second rising tables
      for (k = 0; k < MAX_PTS; k++) begin
         push_load(CH_HOUR, k, 3600 + k * 12000, (k == MAX_PTS - 1) ? DRV_MAX : k * 146, 1'b0);
         push_load(CH_MINUTE, k, 60 + k * 480, DRV_MAX - k * 146, 1'b0);
         push_load(CH_SECOND, k, 2 + k * 8, k * 140, 1'b0);
      end
      wait_idle();

      write_reg(REG_DISCRETE_MODE, 0);
      write_reg(REG_HOUR_POINTS, MAX_PTS);
      write_reg(REG_MINUTE_POINTS, MAX_PTS);
      write_reg(REG_SECOND_POINTS, MAX_PTS);
      csr_valid <= 1'b0;
      // below first point, on first point, on an inner point, interior, past last point
      push_time(0, 0, 0, 1'b0);
      push_time(1, 0, 0, 1'b0);
      push_time(1, 1, 2, 1'b0);
      push_time(4, 20, 0, 1'b0);
      push_time(12, 30, 31, 1'b0);
      push_time(HOURS_MAX, MINSEC_MAX, MINSEC_MAX, 1'b0);
      push_time(HOURS_MAX, 0, MINSEC_MAX + 1, 1'b1);
      push_load(CH_HOUR, 7, 87600, DRV_MAX, 1'b0);
      push_time(23, 59, 59, 1'b0);
      wait_idle();

      // discrete mode, count above table size, single point, empty table
      write_reg(REG_DISCRETE_MODE, 1);
      write_reg(REG_HOUR_POINTS, 15);
      write_reg(REG_MINUTE_POINTS, 1);
      write_reg(REG_SECOND_POINTS, 0);
      write_reg(REG_UNUSED, 6);
      csr_valid <= 1'b0;
      push_time(12, 59, 59, 1'b0);
      push_time(HOURS_MAX, MINSEC_MAX, MINSEC_MAX, 1'b0);
      push_time(0, 0, 0, 1'b1);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         steady = (ph == 4);
         write_reg(REG_DISCRETE_MODE, int'($urandom_range(0, 15)));
         write_reg(REG_HOUR_POINTS, pick_count());
         write_reg(REG_MINUTE_POINTS, pick_count());
         write_reg(REG_SECOND_POINTS, pick_count());
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_INDEX_BITS'(REG_UNUSED + $urandom_range(0, 6)), int'($urandom));
         csr_valid <= 1'b0;
         if ($urandom_range(0, 1) == 0) push_random_table(CHANNEL_BITS'($urandom_range(0, 2)));
         n = 0;
         while (n < PHASE_ITEMS) begin
            push_random_cmd();
            n++;
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
